// ----- rtl/ism_pkg.sv -----
// shared types and constants of the interval statistics monitor
`default_nettype none

package ism_pkg;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int STAMP_W    = 32;
   localparam int SUM_W      = 64;
   localparam int RSP_DATA_W = 4 * STAMP_W;

   localparam logic [STAMP_W-1:0] ALL_ONES = {STAMP_W{1'b1}};

   // action codes carried on the request tuser
   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2
   } action_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SPAN,
      ST_MIN,
      ST_MAX,
      ST_SUM,
      ST_AVG,
      ST_DIV,
      ST_DONE
   } state_type;

   // shared adder operations
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [SUM_W-1:0] result;
      logic             borrow;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/ism_alu.sv -----
// shared add and subtract unit, borrow flag doubles as the compare result
`default_nettype none

module ism_alu (
   input  ism_pkg::alu_req_type req,
   output ism_pkg::alu_rsp_type rsp
);
   import ism_pkg::*;

   logic [SUM_W:0] wide;

   // one wide add or subtract, the top bit gives carry or borrow
   always_comb begin
      unique case (req.op)
         ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
         ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
         default: wide = '0;
      endcase
      rsp.result = wide[SUM_W-1:0];
      rsp.borrow = wide[SUM_W];
   end

endmodule

`default_nettype wire

// ----- rtl/ism_divider.sv -----
// iterative restoring divider, two quotient bits per clock
`default_nettype none

module ism_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ism_pkg::SUM_W-1:0]   dividend,
   input  logic [ism_pkg::STAMP_W-1:0] divisor,
   output logic                        done,
   output logic [ism_pkg::STAMP_W-1:0] quotient
);
   import ism_pkg::*;

   localparam int STEPS   = SUM_W / 2;
   localparam int CNT_W   = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   typedef struct packed {
      logic               qbit;
      logic [STAMP_W-1:0] rem;
   } div_bit_type;

   // one restoring step: shift in a dividend bit, subtract if it fits
   function automatic div_bit_type div_bit(input logic [STAMP_W-1:0] rem,
                                           input logic               in_bit,
                                           input logic [STAMP_W-1:0] den);
      logic [STAMP_W:0]   shifted;
      logic [STAMP_W+1:0] diff;
      div_bit_type        res;
      shifted  = {rem, in_bit};
      diff     = {1'b0, shifted} - {2'b00, den};
      res.qbit = ~diff[STAMP_W+1];
      res.rem  = res.qbit ? diff[STAMP_W-1:0] : shifted[STAMP_W-1:0];
      return res;
   endfunction

   logic [STAMP_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [STAMP_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   div_bit_type        step_hi;
   div_bit_type        step_lo;

   // two chained steps per clock
   always_comb begin
      step_hi = div_bit(rem_ff, quo_ff[SUM_W-1], den_ff);
      step_lo = div_bit(step_hi.rem, quo_ff[SUM_W-2], den_ff);
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = step_lo.rem;
         quo_in = {quo_ff[SUM_W-3:0], step_hi.qbit, step_lo.qbit};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[STAMP_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/interval_stats_monitor.sv -----
// top level of the interval statistics monitor
`default_nettype none

// Each request transfer carries an action (clear, start or stop) on tuser and the
// current timestamp on tdata, and yields exactly one response transfer holding the
// sample count, minimum, maximum and average interval after the action, plus a
// flag that marks a stop which measured. Items are handled one at a time: req_tready
// is high only while the sequencer is idle. A stop while armed steps one shared
// adder through span, minimum, maximum and sum, and a start uses it to raise the
// count; then every action, a clear or an ignored code too, runs the 32-step
// divider for the average, which retires two quotient bits per clock, unless
// the count is zero.
// A finished response waits in its output register while the next request is
// taken; the sequencer holds in its last state until that register is free.

module interval_stats_monitor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // timestamp [31:0]
   input  logic [ism_pkg::STAMP_W-1:0]    req_tdata,
   // action [1:0]
   input  logic [ism_pkg::ACTION_W-1:0]   req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // sample_count [31:0], min_elapsed [63:32], max_elapsed [95:64],
   // average_elapsed [127:96]
   output logic [ism_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // measured [0]
   output logic [0:0]                     rsp_tuser
);
   import ism_pkg::*;

   function automatic logic [SUM_W-1:0] widen(input logic [STAMP_W-1:0] x);
      return {{(SUM_W-STAMP_W){1'b0}}, x};
   endfunction

   state_type             state_ff, state_in;
   logic [STAMP_W-1:0]    ts_ff, ts_in;
   logic [STAMP_W-1:0]    span_ff, span_in;
   logic [STAMP_W-1:0]    start_stamp_ff, start_stamp_in;
   logic                  armed_ff, armed_in;
   logic [STAMP_W-1:0]    min_ff, min_in;
   logic [STAMP_W-1:0]    max_ff, max_in;
   logic [STAMP_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [STAMP_W-1:0]    avg_ff, avg_in;
   logic                  measured_ff, measured_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [0:0]            rsp_tuser_ff, rsp_tuser_in;

   alu_req_type           alu_req;
   alu_rsp_type           alu_rsp;
   logic                  div_start;
   logic                  div_done;
   logic [STAMP_W-1:0]    div_quotient;

   ism_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   ism_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequencer: next state, shared adder operands and register updates
   always_comb begin
      state_in       = state_ff;
      ts_in          = ts_ff;
      span_in        = span_ff;
      start_stamp_in = start_stamp_ff;
      armed_in       = armed_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      avg_in         = avg_ff;
      measured_in    = measured_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tuser_in   = rsp_tuser_ff;
      rsp_tvalid_in  = rsp_tvalid_ff & ~rsp_tready;
      alu_req        = '{op: ALU_ADD, a: '0, b: '0};
      div_start      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ts_in       = req_tdata;
               measured_in = 1'b0;
               unique case (action_type'(req_tuser))
                  ACT_CLEAR: begin
                     start_stamp_in = '0;
                     armed_in       = 1'b0;
                     min_in         = ALL_ONES;
                     max_in         = '0;
                     count_in       = '0;
                     sum_in         = '0;
                     state_in       = ST_AVG;
                  end
                  ACT_START: begin
                     start_stamp_in = req_tdata;
                     armed_in       = 1'b1;
                     state_in       = ST_COUNT;
                  end
                  ACT_STOP: begin
                     state_in = armed_ff ? ST_SPAN : ST_AVG;
                  end
                  default: begin
                     state_in = ST_AVG;
                  end
               endcase
            end
         end
         // one more start
         ST_COUNT: begin
            alu_req  = '{op: ALU_ADD, a: widen(count_ff), b: widen(STAMP_W'(1))};
            count_in = alu_rsp.result[STAMP_W-1:0];
            state_in = ST_AVG;
         end
         // wrapped interval since the latched start
         ST_SPAN: begin
            alu_req  = '{op: ALU_SUB, a: widen(ts_ff), b: widen(start_stamp_ff)};
            span_in  = alu_rsp.result[STAMP_W-1:0];
            state_in = ST_MIN;
         end
         // borrow means span below the minimum
         ST_MIN: begin
            alu_req = '{op: ALU_SUB, a: widen(span_ff), b: widen(min_ff)};
            if (alu_rsp.borrow) begin
               min_in = span_ff;
            end
            state_in = ST_MAX;
         end
         // borrow means span above the maximum
         ST_MAX: begin
            alu_req = '{op: ALU_SUB, a: widen(max_ff), b: widen(span_ff)};
            if (alu_rsp.borrow) begin
               max_in = span_ff;
            end
            state_in = ST_SUM;
         end
         // wrapping running sum
         ST_SUM: begin
            alu_req     = '{op: ALU_ADD, a: sum_ff, b: widen(span_ff)};
            sum_in      = alu_rsp.result;
            measured_in = 1'b1;
            state_in    = ST_AVG;
         end
         // average is zero for an empty count
         ST_AVG: begin
            if (count_ff == '0) begin
               avg_in   = '0;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in   = div_quotient;
               state_in = ST_DONE;
            end
         end
         // load the output register once it is free
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in  = {avg_ff, max_ff, min_ff, count_ff};
               rsp_tuser_in  = measured_ff;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_stamp_ff <= '0;
         armed_ff       <= 1'b0;
         min_ff         <= ALL_ONES;
         max_ff         <= '0;
         count_ff       <= '0;
         sum_ff         <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_stamp_ff <= start_stamp_in;
         armed_ff       <= armed_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ts_ff        <= ts_in;
      span_ff      <= span_in;
      avg_ff       <= avg_in;
      measured_ff  <= measured_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ----- rtl/ism_checker.sv -----
// port level checks of the interval statistics monitor and their binding
`default_nettype none

module ism_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [ism_pkg::STAMP_W-1:0]    req_tdata,
   input wire logic [ism_pkg::ACTION_W-1:0]   req_tuser,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [ism_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [0:0]                     rsp_tuser
);
   import ism_pkg::*;

   logic [STAMP_W-1:0] rsp_min;
   logic [STAMP_W-1:0] rsp_max;
   logic               req_seen;

   assign rsp_min  = rsp_tdata[2*STAMP_W-1:STAMP_W];
   assign rsp_max  = rsp_tdata[3*STAMP_W-1:2*STAMP_W];
   assign req_seen = (req_tdata != '0) || (req_tuser != '0) || 1'b1;

   // a stalled response stays valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response payload changed while stalled");

   // the block is busy right after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_seen |=> !req_tready)
      else $error("request taken while an item is in progress");

   // a measuring stop leaves the minimum at or below the maximum
   a_min_below_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_min <= rsp_max)
      else $error("minimum above maximum after a measurement");

endmodule

bind interval_stats_monitor ism_checker u_ism_checker (.*);

`default_nettype wire
